### rtl/bb_pkg.sv
package bb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 15;
  localparam int MAX_HEIGHT     = 1024;
  localparam int DIV_STEPS      = 16;

  localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

  typedef struct packed {
    logic restart;
    logic accept;
    logic rd_issue;
    logic acc;
    logic wr;
    logic wsum_start;
    logic wsum_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } bb_cmd_t;

  typedef struct packed {
    logic more_rows;
    logic produce;
    logic wsum_done;
    logic div_done;
    logic out_full;
  } bb_sts_t;

endpackage

### rtl/bb_ctrl.sv
module bb_ctrl
  import bb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    restart,
  input  bb_sts_t sts,
  output logic    in_ready,
  output bb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_ACC, S_WR, S_WSUM, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.restart = restart;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.more_rows) begin
          cmd.rd_issue = 1'b1;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = S_RD;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.produce) begin
          cmd.wsum_start = 1'b1;
          state_nxt = S_WSUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WSUM: begin
        if (sts.wsum_done) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.wsum_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/bb_datapath.sv
module bb_datapath
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  bb_cmd_t     cmd,
  output bb_sts_t     sts,
  input  logic [3:0]  kernel_width,
  input  logic [3:0]  kernel_height,
  input  logic [10:0] image_width,
  input  logic [10:0] image_height,
  input  logic [23:0] in_data,
  output logic [23:0] out_data,
  output logic        out_last,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int SLOTS = MAX_KERNEL - 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WX    = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int KI    = $clog2(MAX_KERNEL);
  localparam int DEPTH = SLOTS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] MW        = AW'(MAX_WIDTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  logic [23:0]   px_r;
  logic [CW-1:0] col_r;
  logic [9:0]    row_r;
  logic [SW-1:0] rslot_r, rdslot_r;
  logic [3:0]    kcnt_r, widx_r;
  logic [11:0]   colsum_r [3];
  logic [35:0]   win_r [MAX_KERNEL];
  logic [15:0]   wsum_r [3];
  logic [15:0]   dvd_r [3];
  logic [7:0]    rem_r [3];
  logic [4:0]    dcnt_r;
  logic          last_r;
  logic [23:0]   out_data_r;
  logic          out_last_r, out_valid_r;

  logic [3:0]    kw_e, kh_e;
  logic [WX-1:0] w_e, iw_x, col_x;
  logic [10:0]   h_e, row_x;
  logic [7:0]    divisor;
  logic [AW-1:0] raddr, waddr;
  logic          col_end, row_end;

  always_comb begin
    kw_e = (kernel_width == 4'd0) ? 4'd1 :
           (kernel_width > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_width;
    kh_e = (kernel_height == 4'd0) ? 4'd1 :
           (kernel_height > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_height;
    iw_x = WX'(image_width);
    w_e  = (iw_x == '0) ? WX'(1) : (iw_x > WX'(MAX_WIDTH)) ? WX'(MAX_WIDTH) : iw_x;
    h_e  = (image_height == 11'd0) ? 11'd1 :
           (image_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : image_height;
    divisor = {4'd0, kw_e} * {4'd0, kh_e};
    col_x = WX'(col_r) + WX'(1);
    row_x = {1'b0, row_r} + 11'd1;
    col_end = (col_x >= w_e);
    row_end = (row_x >= h_e);
    raddr = AW'(rdslot_r) * MW + AW'(col_r);
    waddr = AW'(rslot_r) * MW + AW'(col_r);
    sts.more_rows = (kcnt_r < kh_e);
    sts.produce   = (row_x >= {7'd0, kh_e}) && (col_x >= WX'(kw_e));
    sts.wsum_done = (widx_r == kw_e);
    sts.div_done  = (dcnt_r == 5'(DIV_STEPS));
    sts.out_full  = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= px_r;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r     <= in_data;
      kcnt_r   <= 4'd1;
      rdslot_r <= (rslot_r == '0) ? SLOT_LAST : rslot_r - SW'(1);
      for (int c = 0; c < 3; c++) begin
        colsum_r[c] <= {4'd0, in_data[8*c +: 8]};
      end
    end
    if (cmd.acc) begin
      kcnt_r   <= kcnt_r + 4'd1;
      rdslot_r <= (rdslot_r == '0) ? SLOT_LAST : rdslot_r - SW'(1);
      for (int c = 0; c < 3; c++) begin
        colsum_r[c] <= colsum_r[c] + {4'd0, rdata_r[8*c +: 8]};
      end
    end
    if (cmd.wr) begin
      for (int i = MAX_KERNEL - 1; i > 0; i--) begin
        win_r[i] <= win_r[i-1];
      end
      win_r[0] <= {colsum_r[2], colsum_r[1], colsum_r[0]};
      last_r   <= row_end && col_end;
    end
    if (cmd.wsum_start) begin
      widx_r <= 4'd0;
      for (int c = 0; c < 3; c++) begin
        wsum_r[c] <= 16'd0;
      end
    end
    if (cmd.wsum_step) begin
      widx_r <= widx_r + 4'd1;
      for (int c = 0; c < 3; c++) begin
        wsum_r[c] <= wsum_r[c] + {4'd0, win_r[widx_r[KI-1:0]][12*c +: 12]};
      end
    end
    if (cmd.div_start) begin
      dcnt_r <= 5'd0;
      for (int c = 0; c < 3; c++) begin
        dvd_r[c] <= wsum_r[c];
        rem_r[c] <= 8'd0;
      end
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
      for (int c = 0; c < 3; c++) begin
        if ({rem_r[c], dvd_r[c][15]} >= {1'b0, divisor}) begin
          rem_r[c] <= 8'({rem_r[c], dvd_r[c][15]} - {1'b0, divisor});
          dvd_r[c] <= {dvd_r[c][14:0], 1'b1};
        end else begin
          rem_r[c] <= {rem_r[c][6:0], dvd_r[c][15]};
          dvd_r[c] <= {dvd_r[c][14:0], 1'b0};
        end
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {dvd_r[2][7:0], dvd_r[1][7:0], dvd_r[0][7:0]};
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      rslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.restart) begin
        col_r   <= '0;
        row_r   <= '0;
        rslot_r <= '0;
      end else if (cmd.wr) begin
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            row_r   <= '0;
            rslot_r <= '0;
          end else begin
            row_r   <= row_r + 10'd1;
            rslot_r <= (rslot_r == SLOT_LAST) ? '0 : rslot_r + SW'(1);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

endmodule

### rtl/rgb_box_blur.sv
// Per accepted input beat the row loop reads and accumulates each stored kernel row, then
// the column is written; with a window, the serial window sum, divider and output load
// follow. A new pixel is accepted only back in idle, so output stalls also hold input;
// the rate is set by serial reads, window sum and divider.
// Reset (synchronous, rst_n low): registers return to 3, 3, 640, 480, position to zero.
// The line store is not cleared.
module rgb_box_blur
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_mean, green_mean, blue_mean
  output logic        out_tlast,  // frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0]  kw_r, kh_r;
  logic [10:0] iw_r, ih_r;
  logic        wr_en;
  bb_cmd_t     cmd;
  bb_sts_t     sts;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r <= 4'd3;
      kh_r <= 4'd3;
      iw_r <= 11'd640;
      ih_r <= 11'd480;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_KERNEL_WIDTH:  kw_r <= cfg_pwdata[3:0];
        REG_KERNEL_HEIGHT: kh_r <= cfg_pwdata[3:0];
        REG_IMAGE_WIDTH:   iw_r <= cfg_pwdata[10:0];
        REG_IMAGE_HEIGHT:  ih_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_KERNEL_WIDTH:  cfg_prdata = {28'd0, kw_r};
      REG_KERNEL_HEIGHT: cfg_prdata = {28'd0, kh_r};
      REG_IMAGE_WIDTH:   cfg_prdata = {21'd0, iw_r};
      REG_IMAGE_HEIGHT:  cfg_prdata = {21'd0, ih_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  bb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .restart  (wr_en),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  bb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .kernel_width  (kw_r),
    .kernel_height (kh_r),
    .image_width   (iw_r),
    .image_height  (ih_r),
    .in_data       (in_tdata),
    .out_data      (out_tdata),
    .out_last      (out_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready)
  );

  // After an input beat the block does not accept another beat in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A result taken is never replaced by a new one in the same cycle.
  a_out_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("output reloaded while being taken");

endmodule

### sim/rgb_box_blur_tb.sv
`timescale 1ns / 1ps

module rgb_box_blur_tb;
  import bb_pkg::*;

  localparam int LINE_ROWS = MAX_KERNEL_DEF - 1;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PIXEL_TARGET = 1950;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } blur_result_t;

  class blur_scoreboard;
    int unsigned kern_w, kern_h, img_w, img_h;
    int unsigned row_pos, col_pos;
    bit [7:0]  lines[LINE_ROWS][MAX_WIDTH_DEF][3];
    bit [15:0] win_cols[MAX_KERNEL_DEF][3];
    blur_result_t pending[$];
    int errors;

    function new();
      kern_w = 3;
      kern_h = 3;
      img_w = 640;
      img_h = 480;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      foreach (win_cols[i, ch]) win_cols[i][ch] = '0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_KERNEL_WIDTH:  kern_w = 32'(val[3:0]);
        REG_KERNEL_HEIGHT: kern_h = 32'(val[3:0]);
        REG_IMAGE_WIDTH:   img_w = 32'(val[10:0]);
        REG_IMAGE_HEIGHT:  img_h = 32'(val[10:0]);
        default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void note_pixel(logic [23:0] beat);
      int unsigned kw, kh, w, h, r, c, sum, slot;
      bit [7:0] px[3];
      blur_result_t res;
      kw = clip(kern_w, MAX_KERNEL_DEF);
      kh = clip(kern_h, MAX_KERNEL_DEF);
      w = clip(img_w, MAX_WIDTH_DEF);
      h = clip(img_h, MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      px[0] = beat[7:0];
      px[1] = beat[15:8];
      px[2] = beat[23:16];
      for (int i = MAX_KERNEL_DEF - 1; i > 0; i--)
        for (int ch = 0; ch < 3; ch++) win_cols[i][ch] = win_cols[i-1][ch];
      for (int ch = 0; ch < 3; ch++) begin
        sum = 32'(px[ch]);
        for (int k = 1; k < kh; k++) begin
          if (k <= r) begin
            slot = (r - k) % LINE_ROWS;
            sum += 32'(lines[slot][c][ch]);
          end
        end
        win_cols[0][ch] = 16'(sum & 32'hFFF);
      end
      for (int ch = 0; ch < 3; ch++) lines[r % LINE_ROWS][c][ch] = px[ch];
      if (r + 1 >= kh && c + 1 >= kw) begin
        bit [7:0] mean[3];
        for (int ch = 0; ch < 3; ch++) begin
          sum = 0;
          for (int i = 0; i < kw; i++) sum += 32'(win_cols[i][ch]);
          mean[ch] = 8'(sum / (kw * kh));
        end
        res.red = mean[0];
        res.green = mean[1];
        res.blue = mean[2];
        res.last = (r + 1 == h && c + 1 == w);
        pending.push_back(res);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void check_result(logic [23:0] data, logic last);
      blur_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat data=%h last=%b", $realtime, data, last);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (data[7:0] !== exp_res.red) begin
        $display("%0t: red mismatch expected %h actual %h", $realtime, exp_res.red, data[7:0]);
        errors++;
      end
      if (data[15:8] !== exp_res.green) begin
        $display("%0t: green mismatch expected %h actual %h", $realtime, exp_res.green,
                 data[15:8]);
        errors++;
      end
      if (data[23:16] !== exp_res.blue) begin
        $display("%0t: blue mismatch expected %h actual %h", $realtime, exp_res.blue,
                 data[23:16]);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: last mismatch expected %b actual %b", $realtime, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  blur_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned rx_mode = 0;

  rgb_box_blur dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycle_count % 300 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup_image(int unsigned kw, int unsigned kh, int unsigned iw,
                             int unsigned ih);
    logic [1:0] order[4];
    logic [31:0] val;
    order = '{REG_KERNEL_WIDTH, REG_KERNEL_HEIGHT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    order.shuffle();
    foreach (order[i]) begin
      case (order[i])
        REG_KERNEL_WIDTH:  val = {$urandom_range(0, 1) ? $urandom : 32'h0} & 32'hFFFF_FFF0 | kw;
        REG_KERNEL_HEIGHT: val = {$urandom_range(0, 1) ? $urandom : 32'h0} & 32'hFFFF_FFF0 | kh;
        REG_IMAGE_WIDTH:   val = {$urandom_range(0, 1) ? $urandom : 32'h0} & 32'hFFFF_F800 | iw;
        default:           val = {$urandom_range(0, 1) ? $urandom : 32'h0} & 32'hFFFF_F800 | ih;
      endcase
      write_reg(order[i], val);
    end
  endtask

  task automatic send_pixel(logic [23:0] px);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 :
            ($urandom_range(0, 5) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(px);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {3{8'($urandom_range(0, 1) ? 8'hFF : 8'h00)}} ^ 24'($urandom_range(0, 1));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    idle_input();
    wait_drained();
  endtask

  initial begin
    int unsigned kw, kh, iw, ih, n, mode, wfit, hfit;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults from reset: the first row of a wide image gives no output.
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h55AA55);
    send_pixel(24'hAA55AA);
    idle_input();
    wait_drained();

    // Zero sizes act as one: every pixel is its own frame.
    setup_image(0, 0, 0, 0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h123456);
    idle_input();
    wait_drained();

    // Kernel larger than the image: nothing comes out.
    setup_image(15, 15, 4, 4);
    run_phase(8);

    // A full 3x2 frame with a 2x2 kernel at the extremes.
    setup_image(2, 2, 3, 2);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF00FF);
    idle_input();
    wait_drained();

    // Widest kernel on a row of maximum width.
    setup_image(15, 1, 1024, 1);
    run_phase(20);

    while (pixels_sent < PIXEL_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        case ($urandom_range(0, 3))
          0: iw = 1024;
          1: iw = 2047;
          2: iw = 1023;
          default: iw = 0;
        endcase
        kh = $urandom_range(0, 1);
        kw = $urandom_range(0, 15);
        ih = $urandom_range(1, 6);
        n = $urandom_range(20, 60);
      end else if (mode == 1) begin
        case ($urandom_range(0, 2))
          0: ih = 1024;
          1: ih = 2047;
          default: ih = 0;
        endcase
        iw = $urandom_range(1, 3);
        kw = $urandom_range(0, iw);
        kh = $urandom_range(0, 15);
        n = $urandom_range(30, 90);
      end else begin
        iw = $urandom_range(1, 24);
        ih = $urandom_range(1, 18);
        wfit = (iw < 15) ? iw : 15;
        hfit = (ih < 15) ? ih : 15;
        if ($urandom_range(0, 9) < 8) begin
          kw = $urandom_range(1, wfit);
          kh = $urandom_range(1, hfit);
        end else begin
          kw = $urandom_range(0, 15);
          kh = $urandom_range(0, 15);
        end
        n = iw * ih * $urandom_range(1, 3) + (($urandom_range(0, 2) == 0) ?
            $urandom_range(0, 20) : 0);
        if (n > 250) n = $urandom_range(100, 250);
      end
      setup_image(kw, kh, iw, ih);
      run_phase(n);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/bb_pkg.sv
rtl/bb_ctrl.sv
rtl/bb_datapath.sv
rtl/rgb_box_blur.sv
sim/rgb_box_blur_tb.sv
